// File: src/two_link_inverse_kinematics_unit_defines.svh
// Assertion macros used by the checker file of the two-link IK block.
`ifndef TWO_LINK_INVERSE_KINEMATICS_UNIT_DEFINES_SVH
`define TWO_LINK_INVERSE_KINEMATICS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLIK_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLIK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tlik_pkg.sv
// Types, constants and helper functions of the two-link IK block.
package tlik_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_REACH,
        ST_SQ_L1,
        ST_SQ_L2,
        ST_ROOT,
        ST_DEN,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQ_C,
        ST_CINIT,
        ST_CORDIC,
        ST_FINISH,
        ST_DUTY_SH,
        ST_DUTY_EL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        COR_ACOS1,
        COR_ATAN,
        COR_ACOS2
    } cor_sel_t;

    localparam logic [1:0] REG_FIRST_LINK  = 2'd0;
    localparam logic [1:0] REG_SECOND_LINK = 2'd1;
    localparam logic [1:0] REG_DUTY_GAIN   = 2'd2;
    localparam logic [1:0] REG_DUTY_OFFSET = 2'd3;

    localparam int CNT_W = 5;

    localparam logic signed [24:0] DEG90  = 25'sd1474560;
    localparam logic signed [24:0] DEG180 = 25'sd2949120;
    localparam logic signed [24:0] DEG360 = 25'sd5898240;

    localparam logic [31:0] Q30_ONE = 32'h4000_0000;
    localparam logic signed [15:0] SH_OFFSET = 16'sd5760;
    localparam logic signed [24:0] EL_MAX = 25'sd11520;

    // Arctangent of 2^-i in 1/16384 degree.
    function automatic logic [20:0] atan_entry(input logic [4:0] idx);
        logic [20:0] v;
        case (idx)
            5'd0:    v = 21'd737280;
            5'd1:    v = 21'd435242;
            5'd2:    v = 21'd229970;
            5'd3:    v = 21'd116736;
            5'd4:    v = 21'd58595;
            5'd5:    v = 21'd29326;
            5'd6:    v = 21'd14667;
            5'd7:    v = 21'd7334;
            5'd8:    v = 21'd3667;
            5'd9:    v = 21'd1833;
            5'd10:   v = 21'd917;
            5'd11:   v = 21'd458;
            5'd12:   v = 21'd229;
            5'd13:   v = 21'd115;
            5'd14:   v = 21'd57;
            5'd15:   v = 21'd29;
            5'd16:   v = 21'd14;
            5'd17:   v = 21'd7;
            5'd18:   v = 21'd4;
            5'd19:   v = 21'd2;
            5'd20:   v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

    // Rounded gain product plus offset, saturated to 16 bits.
    function automatic logic [15:0] duty_of(input logic signed [35:0] p,
                                            input logic [15:0] off);
        logic signed [36:0] t;
        logic signed [22:0] d;
        logic [15:0] r;
        t = 37'(p) + 37'sd8192;
        d = 23'(t >>> 14) + $signed({7'b0, off});
        if (d < 0)
            r = 16'd0;
        else if (d > 23'sd65535)
            r = 16'hFFFF;
        else
            r = d[15:0];
        return r;
    endfunction

endpackage

// File: src/two_link_inverse_kinematics_unit.sv
// Two-link planar inverse kinematics with servo duty mapping.
// A point out of reach skips the solver, and a cosine that saturates skips its divider loop.
// One item at a time; s_tready rises in the cycle the result enters the output register.
// The datapath uses one shared 18x18 multiplier, a square-root, divider and CORDIC loop.
// rst_n clears control state and the held angles and sets the configuration registers to their defaults.
module two_link_inverse_kinematics_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // x_pos[15:0], y_pos[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // shoulder_angle, elbow_angle, shoulder_duty, elbow_duty
    output logic [0:0]  m_tuser,    // reachable
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = tlik_pkg::CNT_W;

    tlik_pkg::state_t   state_reg, state_next;
    tlik_pkg::cor_sel_t cor_sel_reg, cor_sel_next;

    logic [6:0]  l1_len_reg, l2_len_reg;
    logic [15:0] gain_reg, offset_reg;
    logic signed [15:0] held_sh_reg, held_sh_next;
    logic [13:0] held_el_reg, held_el_next;
    logic out_valid_reg, out_valid_next;
    logic div_sel_reg, div_sel_next;
    logic root_sel_reg, root_sel_next;

    logic signed [15:0] x_reg, x_next, y_reg, y_next;
    logic [31:0] r2_reg, r2_next;
    logic ok_reg, ok_next;
    logic [30:0] l1sq_reg, l1sq_next, l2sq_reg, l2sq_next;
    logic [15:0] r_reg, r_next;
    logic [31:0] den_reg, den_next;
    logic [33:0] rem_reg, rem_next;
    logic [16:0] dlo_reg, dlo_next, q_reg, q_next;
    logic neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic signed [16:0] c1_reg, c1_next, c2_reg, c2_next, cx_reg, cx_next;
    logic [31:0] rv_reg, rv_next, rres_reg, rres_next, rbit_reg, rbit_next;
    logic signed [27:0] cx_x_reg, cx_x_next, cx_y_reg, cx_y_next;
    logic signed [23:0] z_reg, z_next, a1_reg, a1_next, th1_reg, th1_next;
    logic signed [35:0] prod_reg, prod_next;
    logic [15:0] dsh_reg, dsh_next;
    logic [63:0] out_data_reg, out_data_next;
    logic out_user_reg, out_user_next;

    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;
    logic [14:0] l1_s, l2_s;
    logic [15:0] reach_len;
    logic [31:0] root_sum;
    logic root_ge;
    logic signed [33:0] div_num;
    logic [33:0] div_mag;
    logic div_sat;
    logic [33:0] div_t;
    logic div_ge;
    logic [16:0] q_fin, q_clamp;
    logic signed [16:0] c_div, c_sat;
    logic signed [17:0] cor_x0, cor_y0;
    logic signed [27:0] x0_s, y0_s, cor_dx, cor_dy;
    logic signed [23:0] tab_s;
    logic signed [24:0] th1_w, th2_w, sh_rnd, el_rnd;
    logic signed [15:0] sh_val;

    assign l1_s      = {l1_len_reg, 8'b0};
    assign l2_s      = {l2_len_reg, 8'b0};
    assign reach_len = {({1'b0, l1_len_reg} + {1'b0, l2_len_reg}), 8'b0};
    assign mul_p     = mul_a * mul_b;
    assign sh_val    = held_sh_reg + tlik_pkg::SH_OFFSET;

    assign s_tready = (state_reg == tlik_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            tlik_pkg::ST_SQ_X:
            begin
                mul_a = 18'(x_reg);
                mul_b = 18'(x_reg);
            end
            tlik_pkg::ST_SQ_Y:
            begin
                mul_a = 18'(y_reg);
                mul_b = 18'(y_reg);
            end
            tlik_pkg::ST_REACH:
            begin
                mul_a = $signed({2'b0, reach_len});
                mul_b = $signed({2'b0, reach_len});
            end
            tlik_pkg::ST_SQ_L1:
            begin
                mul_a = $signed({3'b0, l1_s});
                mul_b = $signed({3'b0, l1_s});
            end
            tlik_pkg::ST_SQ_L2:
            begin
                mul_a = $signed({3'b0, l2_s});
                mul_b = $signed({3'b0, l2_s});
            end
            tlik_pkg::ST_DEN:
            begin
                mul_a = $signed({3'b0, l1_s});
                mul_b = div_sel_reg ? $signed({3'b0, l2_s}) : $signed({2'b0, r_reg});
            end
            tlik_pkg::ST_SQ_C:
            begin
                mul_a = (cor_sel_reg == tlik_pkg::COR_ACOS1) ? 18'(c1_reg) : 18'(c2_reg);
                mul_b = mul_a;
            end
            tlik_pkg::ST_DUTY_SH:
            begin
                mul_a = $signed({2'b0, gain_reg});
                mul_b = 18'(sh_val);
            end
            tlik_pkg::ST_DUTY_EL:
            begin
                mul_a = $signed({2'b0, gain_reg});
                mul_b = $signed({4'b0, held_el_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Datapath helpers for the square root, divider and CORDIC steps.
    always_comb
    begin
        root_sum = rres_reg + rbit_reg;
        root_ge  = (rv_reg >= root_sum);

        if (div_sel_reg)
            div_num = $signed({3'b0, l1sq_reg}) + $signed({3'b0, l2sq_reg})
                    - $signed({2'b0, r2_reg});
        else
            div_num = $signed({2'b0, r2_reg}) + $signed({3'b0, l1sq_reg})
                    - $signed({3'b0, l2sq_reg});
        div_mag = div_num[33] ? 34'(-div_num) : 34'(div_num);
        // A quotient of 2^17 or more only ever clamps, so it is caught before the loop.
        div_sat = (div_mag >= {den_reg, 2'b0});
        c_sat   = div_num[33] ? -17'sd32768 : 17'sd32768;

        div_t   = {rem_reg[32:0], dlo_reg[16]};
        div_ge  = (div_t >= {2'b0, den_reg});
        q_fin   = {q_reg[15:0], div_ge};
        q_clamp = (q_fin > 17'd32768) ? 17'd32768 : q_fin;
        c_div   = neg_reg ? -$signed(q_clamp) : $signed(q_clamp);

        if (cor_sel_reg == tlik_pkg::COR_ATAN)
        begin
            cor_x0 = 18'(x_reg);
            cor_y0 = 18'(y_reg);
        end
        else
        begin
            cor_x0 = 18'(cx_reg);
            cor_y0 = $signed({2'b0, r_reg});
        end
        x0_s = 28'(cor_x0) <<< 8;
        y0_s = 28'(cor_y0) <<< 8;

        cor_dx = cx_y_reg >>> cnt_reg;
        cor_dy = cx_x_reg >>> cnt_reg;
        tab_s  = $signed({3'b0, tlik_pkg::atan_entry(5'(cnt_reg))});

        th1_w = 25'(th1_reg);
        if (th1_w <= -tlik_pkg::DEG180)
            th1_w = th1_w + tlik_pkg::DEG360;
        else if (th1_w > tlik_pkg::DEG180)
            th1_w = th1_w - tlik_pkg::DEG360;
        sh_rnd = (th1_w + 25'sd128) >>> 8;
        th2_w  = tlik_pkg::DEG180 - 25'(z_reg);
        el_rnd = (th2_w + 25'sd128) >>> 8;
        if (el_rnd < 0)
            el_rnd = '0;
        else if (el_rnd > tlik_pkg::EL_MAX)
            el_rnd = tlik_pkg::EL_MAX;
    end

    // Sequencer: next state and register updates.
    always_comb
    begin
        state_next    = state_reg;
        cor_sel_next  = cor_sel_reg;
        held_sh_next  = held_sh_reg;
        held_el_next  = held_el_reg;
        out_valid_next = out_valid_reg;
        div_sel_next  = div_sel_reg;
        root_sel_next = root_sel_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        r2_next       = r2_reg;
        ok_next       = ok_reg;
        l1sq_next     = l1sq_reg;
        l2sq_next     = l2sq_reg;
        r_next        = r_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        dlo_next      = dlo_reg;
        q_next        = q_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        c1_next       = c1_reg;
        c2_next       = c2_reg;
        cx_next       = cx_reg;
        rv_next       = rv_reg;
        rres_next     = rres_reg;
        rbit_next     = rbit_reg;
        cx_x_next     = cx_x_reg;
        cx_y_next     = cx_y_reg;
        z_next        = z_reg;
        a1_next       = a1_reg;
        th1_next      = th1_reg;
        prod_next     = prod_reg;
        dsh_next      = dsh_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            tlik_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next     = s_tdata[15:0];
                    y_next     = s_tdata[31:16];
                    state_next = tlik_pkg::ST_SQ_X;
                end
            end
            tlik_pkg::ST_SQ_X:
            begin
                r2_next    = mul_p[31:0];
                state_next = tlik_pkg::ST_SQ_Y;
            end
            tlik_pkg::ST_SQ_Y:
            begin
                r2_next    = r2_reg + mul_p[31:0];
                state_next = tlik_pkg::ST_REACH;
            end
            tlik_pkg::ST_REACH:
            begin
                ok_next = (r2_reg != '0) && ({4'b0, r2_reg} <= $unsigned(mul_p))
                          && (l1_len_reg != '0) && (l2_len_reg != '0);
                state_next = ok_next ? tlik_pkg::ST_SQ_L1 : tlik_pkg::ST_DUTY_SH;
            end
            tlik_pkg::ST_SQ_L1:
            begin
                l1sq_next  = mul_p[30:0];
                state_next = tlik_pkg::ST_SQ_L2;
            end
            tlik_pkg::ST_SQ_L2:
            begin
                l2sq_next     = mul_p[30:0];
                rv_next       = r2_reg;
                rres_next     = '0;
                rbit_next     = tlik_pkg::Q30_ONE;
                cnt_next      = '0;
                root_sel_next = 1'b0;
                div_sel_next  = 1'b0;
                state_next    = tlik_pkg::ST_ROOT;
            end
            tlik_pkg::ST_ROOT:
            begin
                if (root_ge)
                begin
                    rv_next   = rv_reg - root_sum;
                    rres_next = (rres_reg >> 1) + rbit_reg;
                end
                else
                begin
                    rres_next = rres_reg >> 1;
                end
                rbit_next = rbit_reg >> 2;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(15))
                begin
                    r_next     = rres_next[15:0];
                    state_next = root_sel_reg ? tlik_pkg::ST_CINIT : tlik_pkg::ST_DEN;
                end
            end
            tlik_pkg::ST_DEN:
            begin
                den_next   = {mul_p[30:0], 1'b0};
                state_next = tlik_pkg::ST_DIV_INIT;
            end
            tlik_pkg::ST_DIV_INIT:
            begin
                neg_next = div_num[33];
                rem_next = {2'b0, div_mag[33:2]};
                dlo_next = {div_mag[1:0], 15'b0};
                q_next   = '0;
                cnt_next = '0;
                if (div_sat)
                begin
                    if (div_sel_reg)
                    begin
                        c2_next      = c_sat;
                        cor_sel_next = tlik_pkg::COR_ACOS1;
                        state_next   = tlik_pkg::ST_SQ_C;
                    end
                    else
                    begin
                        c1_next      = c_sat;
                        div_sel_next = 1'b1;
                        state_next   = tlik_pkg::ST_DEN;
                    end
                end
                else
                begin
                    state_next = tlik_pkg::ST_DIV;
                end
            end
            tlik_pkg::ST_DIV:
            begin
                rem_next = div_ge ? (div_t - {2'b0, den_reg}) : div_t;
                dlo_next = {dlo_reg[15:0], 1'b0};
                q_next   = q_fin;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(16))
                begin
                    if (div_sel_reg)
                    begin
                        c2_next      = c_div;
                        cor_sel_next = tlik_pkg::COR_ACOS1;
                        state_next   = tlik_pkg::ST_SQ_C;
                    end
                    else
                    begin
                        c1_next      = c_div;
                        div_sel_next = 1'b1;
                        state_next   = tlik_pkg::ST_DEN;
                    end
                end
            end
            tlik_pkg::ST_SQ_C:
            begin
                // The acos operand pair (x, y) is (c, sqrt(1 - c^2)) in Q15.
                cx_next       = mul_a[16:0];
                rv_next       = tlik_pkg::Q30_ONE - mul_p[31:0];
                rres_next     = '0;
                rbit_next     = tlik_pkg::Q30_ONE;
                cnt_next      = '0;
                root_sel_next = 1'b1;
                state_next    = tlik_pkg::ST_ROOT;
            end
            tlik_pkg::ST_CINIT:
            begin
                cnt_next = '0;
                if (x0_s < 0)
                begin
                    if (y0_s >= 0)
                    begin
                        cx_x_next = y0_s;
                        cx_y_next = -x0_s;
                        z_next    = 24'(tlik_pkg::DEG90);
                    end
                    else
                    begin
                        cx_x_next = -y0_s;
                        cx_y_next = x0_s;
                        z_next    = 24'(-tlik_pkg::DEG90);
                    end
                end
                else
                begin
                    cx_x_next = x0_s;
                    cx_y_next = y0_s;
                    z_next    = '0;
                end
                state_next = tlik_pkg::ST_CORDIC;
            end
            tlik_pkg::ST_CORDIC:
            begin
                if (cx_y_reg > 0)
                begin
                    cx_x_next = cx_x_reg + cor_dx;
                    cx_y_next = cx_y_reg - cor_dy;
                    z_next    = z_reg + tab_s;
                end
                else
                begin
                    cx_x_next = cx_x_reg - cor_dx;
                    cx_y_next = cx_y_reg + cor_dy;
                    z_next    = z_reg - tab_s;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(CORDIC_STEPS - 1))
                begin
                    case (cor_sel_reg)
                        tlik_pkg::COR_ACOS1:
                        begin
                            a1_next      = z_next;
                            cor_sel_next = tlik_pkg::COR_ATAN;
                            state_next   = tlik_pkg::ST_CINIT;
                        end
                        tlik_pkg::COR_ATAN:
                        begin
                            th1_next     = z_next - a1_reg;
                            cor_sel_next = tlik_pkg::COR_ACOS2;
                            state_next   = tlik_pkg::ST_SQ_C;
                        end
                        default:
                        begin
                            state_next = tlik_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            tlik_pkg::ST_FINISH:
            begin
                held_sh_next = sh_rnd[15:0];
                held_el_next = el_rnd[13:0];
                state_next   = tlik_pkg::ST_DUTY_SH;
            end
            tlik_pkg::ST_DUTY_SH:
            begin
                prod_next  = mul_p;
                state_next = tlik_pkg::ST_DUTY_EL;
            end
            tlik_pkg::ST_DUTY_EL:
            begin
                dsh_next   = tlik_pkg::duty_of(prod_reg, offset_reg);
                prod_next  = mul_p;
                state_next = tlik_pkg::ST_OUT;
            end
            tlik_pkg::ST_OUT:
            begin
                // Wait here until the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {2'b0, tlik_pkg::duty_of(prod_reg, offset_reg), dsh_reg,
                                      held_el_reg, sh_val};
                    out_user_next  = ok_reg;
                    out_valid_next = 1'b1;
                    state_next     = tlik_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlik_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlik_pkg::ST_IDLE;
            cor_sel_reg   <= tlik_pkg::COR_ACOS1;
            div_sel_reg   <= 1'b0;
            root_sel_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_sh_reg   <= '0;
            held_el_reg   <= '0;
            l1_len_reg    <= 7'd12;
            l2_len_reg    <= 7'd17;
            gain_reg      <= 16'd9060;
            offset_reg    <= 16'd1147;
        end
        else
        begin
            state_reg     <= state_next;
            cor_sel_reg   <= cor_sel_next;
            div_sel_reg   <= div_sel_next;
            root_sel_reg  <= root_sel_next;
            out_valid_reg <= out_valid_next;
            held_sh_reg   <= held_sh_next;
            held_el_reg   <= held_el_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tlik_pkg::REG_FIRST_LINK:  l1_len_reg <= cfg_data[6:0];
                    tlik_pkg::REG_SECOND_LINK: l2_len_reg <= cfg_data[6:0];
                    tlik_pkg::REG_DUTY_GAIN:   gain_reg   <= cfg_data;
                    tlik_pkg::REG_DUTY_OFFSET: offset_reg <= cfg_data;
                    default:                   l1_len_reg <= l1_len_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        r2_reg       <= r2_next;
        ok_reg       <= ok_next;
        l1sq_reg     <= l1sq_next;
        l2sq_reg     <= l2sq_next;
        r_reg        <= r_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        dlo_reg      <= dlo_next;
        q_reg        <= q_next;
        neg_reg      <= neg_next;
        cnt_reg      <= cnt_next;
        c1_reg       <= c1_next;
        c2_reg       <= c2_next;
        cx_reg       <= cx_next;
        rv_reg       <= rv_next;
        rres_reg     <= rres_next;
        rbit_reg     <= rbit_next;
        cx_x_reg     <= cx_x_next;
        cx_y_reg     <= cx_y_next;
        z_reg        <= z_next;
        a1_reg       <= a1_next;
        th1_reg      <= th1_next;
        prod_reg     <= prod_next;
        dsh_reg      <= dsh_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule

// File: src/tlik_checker.sv
// Port-level checker for the two-link IK block, bound to the top level.
`include "two_link_inverse_kinematics_unit_defines.svh"

module tlik_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    `TLIK_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")

    `TLIK_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "input accepted while an item is in work")

    `TLIK_ASSERT_IMPLY(a_elbow_range, clk, rst_n, m_tvalid, m_tdata[29:16] <= 14'd11520, "elbow angle beyond 180 degrees")

    `TLIK_ASSERT_IMPLY(a_shoulder_range, clk, rst_n, m_tvalid, ($signed(m_tdata[15:0]) >= -16'sd5760) && ($signed(m_tdata[15:0]) <= 16'sd17280), "shoulder angle out of range")

endmodule

bind two_link_inverse_kinematics_unit tlik_checker u_tlik_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
